// ===== rtl/apsq_pkg.sv =====
package apsq_pkg;

    // Bus status codes
    localparam logic [1:0] BUS_IDLE = 2'd0;
    localparam logic [1:0] BUS_BUSY = 2'd1;

    // Bus command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_TX   = 2'd1;
    localparam logic [1:0] CMD_RX   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT_LIMIT = 1'b0;
    localparam logic CFG_COMMAND_BYTE  = 1'b1;

    // Configuration reset values
    localparam logic [2:0] TIMEOUT_LIMIT_RST = 3'd6;
    localparam logic [7:0] COMMAND_BYTE_RST  = 8'h70;

    // Received word layout
    localparam int ALERT_BIT = 6;
    localparam int TAG_LSB   = 4;

    typedef struct packed {
        logic [1:0] bus_status;
        logic [7:0] rx_high_byte;
        logic [7:0] rx_low_byte;
        logic       start_refused;
    } item_t;

    typedef struct packed {
        logic [1:0]  bus_command;
        logic [7:0]  tx_byte;
        logic        stop_after;
        logic        result_valid;
        logic [1:0]  result_channel;
        logic [11:0] result_code;
        logic        failure;
    } result_t;

    typedef struct packed {
        logic [2:0] timeout_limit;
        logic [7:0] command_byte;
    } cfg_t;

endpackage

// ===== rtl/apsq_seq.sv =====
module apsq_seq
    import apsq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_TX    = 3'd1,
        PH_RX0   = 3'd2,
        PH_RX1   = 3'd3,
        PH_RX2   = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] tick_reg, tick_next;

    logic [3:0] tick_inc;
    logic       timeout;
    logic       proceed;
    logic       issue_tx;
    logic       issue_rx;
    logic [1:0] chan;
    logic       word_ok;

    always_comb
    begin
        tick_inc = {1'b0, tick_reg} + 4'd1;
        timeout  = tick_inc >= {1'b0, cfg.timeout_limit};
        chan     = 2'(phase_reg - PH_RX0);
        word_ok  = !item.rx_high_byte[ALERT_BIT]
                   && (item.rx_high_byte[TAG_LSB +: 2] == chan);

        res        = '0;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        proceed    = 1'b0;
        issue_tx   = 1'b0;
        issue_rx   = 1'b0;

        case (phase_reg)
            PH_START:
            begin
                issue_tx = 1'b1;
            end
            PH_TX, PH_RX0, PH_RX1, PH_RX2:
            begin
                tick_next = tick_inc[3] ? 3'd7 : tick_inc[2:0];
                if (item.bus_status == BUS_IDLE)
                begin
                    proceed = 1'b1;
                    if (phase_reg != PH_TX)
                    begin
                        if (word_ok)
                        begin
                            res.result_valid   = 1'b1;
                            res.result_channel = chan;
                            res.result_code    = {item.rx_high_byte[3:0], item.rx_low_byte};
                        end
                        else
                        begin
                            res.failure = 1'b1;
                        end
                    end
                end
                else if (item.bus_status == BUS_BUSY)
                begin
                    proceed     = timeout;
                    res.failure = timeout;
                end
                else
                begin
                    // bus error: flag it, move on only once the wait has run out
                    proceed     = timeout;
                    res.failure = 1'b1;
                end
                issue_tx = proceed && (phase_reg == PH_RX2);
                issue_rx = proceed && (phase_reg != PH_RX2);
            end
            default:
            begin
                res.failure = 1'b1;
                phase_next  = PH_START;
            end
        endcase

        if (issue_tx)
        begin
            tick_next       = '0;
            res.bus_command = CMD_TX;
            res.tx_byte     = cfg.command_byte;
            if (item.start_refused)
                res.failure = 1'b1;
            else
                phase_next = PH_TX;
        end

        if (issue_rx)
        begin
            tick_next       = '0;
            res.bus_command = CMD_RX;
            res.stop_after  = (phase_reg == PH_RX1);
            if (item.start_refused)
            begin
                res.failure = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_TX:   phase_next = PH_RX0;
                    PH_RX0:  phase_next = PH_RX1;
                    PH_RX1:  phase_next = PH_RX2;
                    default: phase_next = PH_START;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            tick_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

// ===== rtl/adc_poll_read_sequencer_unit.sv =====
// Poll-and-read sequencer for a serial-bus converter.
//
// Input channel (in_valid / in_stall): one word per tick carries the bus
// status, the two received bytes and the start-refused flag. Output channel
// (out_valid / out_stall): one word per tick carries the next bus command,
// the byte to send, the stop flag, a checked 12-bit code with its channel,
// and a failure flag. Every input word yields exactly one output word.
//
// An input word lands in the input register when accepted; the sequencer state
// and result register update when the result register is free or draining; out_valid
// rises with them. Throughput is one word per cycle while the receiver does not
// stall, set by the single pass of the sequencer logic between the two registers.
//
// When the receiver stalls, the result register holds its word; one more
// input word is taken into the input register, then in_stall rises until the
// result is taken. Configuration (cfg_valid / cfg_ready, always ready) takes
// index 0 timeout limit, index 1 command byte; write it only while idle.
//
// Reset clears both valid flags, returns the sequencer to its start phase with
// a zero tick count, and loads timeout limit 6 and command byte 0x70.
module adc_poll_read_sequencer_unit
    import apsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  bus_status,
    input  logic [7:0]  rx_high_byte,
    input  logic [7:0]  rx_low_byte,
    input  logic        start_refused,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  bus_command,
    output logic [7:0]  tx_byte,
    output logic        stop_after,
    output logic        result_valid,
    output logic [1:0]  result_channel,
    output logic [11:0] result_code,
    output logic        failure
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;

    logic    in_take;
    logic    step;

    // Advance the held input word whenever the result register is free or
    // being drained this cycle.
    assign step      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    apsq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit <= TIMEOUT_LIMIT_RST;
            cfg_reg.command_byte  <= COMMAND_BYTE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_data[2:0];
                CFG_COMMAND_BYTE:  cfg_reg.command_byte  <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register: load on accept, drop once passed to the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.bus_status    <= bus_status;
            in_item_reg.rx_high_byte  <= rx_high_byte;
            in_item_reg.rx_low_byte   <= rx_low_byte;
            in_item_reg.start_refused <= start_refused;
        end
    end

    // Result register: hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign bus_command    = out_res_reg.bus_command;
    assign tx_byte        = out_res_reg.tx_byte;
    assign stop_after     = out_res_reg.stop_after;
    assign result_valid   = out_res_reg.result_valid;
    assign result_channel = out_res_reg.result_channel;
    assign result_code    = out_res_reg.result_code;
    assign failure        = out_res_reg.failure;

endmodule

// ===== verif/apsq_sequence_checker.sv =====
`timescale 1ns / 1ps

module apsq_sequence_checker
    import apsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  bus_status,
    input  logic [7:0]  rx_high_byte,
    input  logic [7:0]  rx_low_byte,
    input  logic        start_refused,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  bus_command,
    input  logic [7:0]  tx_byte,
    input  logic        stop_after,
    input  logic        result_valid,
    input  logic [1:0]  result_channel,
    input  logic [11:0] result_code,
    input  logic        failure,

    output int          mismatches,
    output int          pending_words,
    output logic [1:0]  next_tag
);

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_TX_WAIT  = 3'd1,
        PH_CH0_WAIT = 3'd2,
        PH_CH1_WAIT = 3'd3,
        PH_CH2_WAIT = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] ticks;
    } seq_t;

    seq_t       seq_state;
    logic [2:0] limit_reg;
    logic [7:0] cmd_reg;
    result_t    awaited_words[$];

    // One tick of the sequencer: the output word and the state that follows.
    function automatic result_t sequencer_tick(input seq_t cur, input item_t w,
                                               input logic [2:0] lim,
                                               input logic [7:0] cmd,
                                               output seq_t nxt);
        result_t    r;
        logic [3:0] inc;
        logic [2:0] offs;
        logic       tmo;
        logic       proceed;
        r = '0;
        nxt = cur;
        proceed = 1'b0;
        offs = cur.phase - PH_CH0_WAIT;
        case (cur.phase)
            PH_START:
                proceed = 1'b1;
            PH_TX_WAIT, PH_CH0_WAIT, PH_CH1_WAIT, PH_CH2_WAIT:
            begin
                inc = {1'b0, cur.ticks} + 4'd1;
                tmo = inc >= {1'b0, lim};
                nxt.ticks = inc[3] ? 3'd7 : inc[2:0];
                if (w.bus_status == BUS_IDLE)
                begin
                    if (cur.phase != PH_TX_WAIT)
                    begin
                        if (!w.rx_high_byte[ALERT_BIT]
                            && w.rx_high_byte[TAG_LSB +: 2] == offs[1:0])
                        begin
                            r.result_valid   = 1'b1;
                            r.result_channel = offs[1:0];
                            r.result_code    = {w.rx_high_byte[3:0], w.rx_low_byte};
                        end
                        else
                            r.failure = 1'b1;
                    end
                    proceed = 1'b1;
                end
                else if (w.bus_status == BUS_BUSY)
                begin
                    if (tmo)
                    begin
                        r.failure = 1'b1;
                        proceed = 1'b1;
                    end
                end
                else
                begin
                    r.failure = 1'b1;
                    proceed = tmo;
                end
            end
            default:
            begin
                r.failure = 1'b1;
                nxt.phase = PH_START;
            end
        endcase
        if (proceed)
        begin
            nxt.ticks = 3'd0;
            if (cur.phase == PH_START || cur.phase == PH_CH2_WAIT)
            begin
                r.bus_command = CMD_TX;
                r.tx_byte     = cmd;
            end
            else
            begin
                r.bus_command = CMD_RX;
                r.stop_after  = (cur.phase == PH_CH1_WAIT);
            end
            // a refused start keeps the phase for another try
            if (w.start_refused)
                r.failure = 1'b1;
            else if (r.bus_command == CMD_TX)
                nxt.phase = PH_TX_WAIT;
            else
                nxt.phase = phase_t'(cur.phase + 3'd1);
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Expected read channel once the word now on the input is taken.
    always_comb
    begin : lookahead
        seq_t    after;
        result_t unused;
        unused = sequencer_tick(seq_state,
                                '{bus_status, rx_high_byte, rx_low_byte, start_refused},
                                limit_reg, cmd_reg, after);
        next_tag = (after.phase >= PH_CH0_WAIT) ? 2'(after.phase - PH_CH0_WAIT) : 2'd0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        seq_t    after;
        if (!rst_n)
        begin
            seq_state     <= '{PH_START, 3'd0};
            limit_reg     <= TIMEOUT_LIMIT_RST;
            cmd_reg       <= COMMAND_BYTE_RST;
            mismatches    <= 0;
            pending_words <= 0;
            awaited_words.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{bus_command, tx_byte, stop_after, result_valid,
                        result_channel, result_code, failure};
                if (awaited_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: output word expected none, got %h", $time, got);
                end
                else
                begin
                    want = awaited_words.pop_front();
                    compare_field("bus_command", want.bus_command, got.bus_command);
                    compare_field("tx_byte", want.tx_byte, got.tx_byte);
                    compare_field("stop_after", want.stop_after, got.stop_after);
                    compare_field("result_valid", want.result_valid, got.result_valid);
                    compare_field("result_channel", want.result_channel,
                                  got.result_channel);
                    compare_field("result_code", want.result_code, got.result_code);
                    compare_field("failure", want.failure, got.failure);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TIMEOUT_LIMIT)
                    limit_reg <= cfg_data[2:0];
                else
                    cmd_reg <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                awaited_words.push_back(sequencer_tick(seq_state,
                    '{bus_status, rx_high_byte, rx_low_byte, start_refused},
                    limit_reg, cmd_reg, after));
                seq_state <= after;
            end
            pending_words <= awaited_words.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import apsq_pkg::*;

    // Status codes beyond idle and busy; both count as a bus error.
    localparam logic [1:0] BUS_ERROR   = 2'd2;
    localparam logic [1:0] BUS_UNKNOWN = 2'd3;

    // Negedges in a row with no handshake on any channel before giving up.
    localparam int STALL_LIMIT = 500;
    localparam int SEGMENTS    = 8;
    localparam int SEG_WORDS   = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_TIMEOUT_LIMIT;
    logic [7:0]  cfg_data = 8'd0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  bus_status = BUS_IDLE;
    logic [7:0]  rx_high_byte = 8'd0;
    logic [7:0]  rx_low_byte = 8'd0;
    logic        start_refused = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  bus_command;
    logic [7:0]  tx_byte;
    logic        stop_after;
    logic        result_valid;
    logic [1:0]  result_channel;
    logic [11:0] result_code;
    logic        failure;

    int          mismatches;
    int          pending_words;
    logic [1:0]  next_tag;

    // Stimulus bookkeeping
    logic        quiet = 1'b0;      // no gaps and no stalls while set
    logic [1:0]  tag_hint = 2'd0;   // channel the block will read next
    int          run_left = 0;
    logic [1:0]  run_status = BUS_BUSY;

    adc_poll_read_sequencer_unit dut (.*);

    apsq_sequence_checker checker_i (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Present one input word after a random gap and hold it until taken.
    // The channel the block expects next is captured on the way, so the
    // following word can carry the right tag.
    task automatic put_word(input logic [1:0] st, input logic [7:0] hi,
                            input logic [7:0] lo, input logic refused);
        int   gap;
        logic took;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        bus_status    <= st;
        rx_high_byte  <= hi;
        rx_low_byte   <= lo;
        start_refused <= refused;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
                tag_hint = next_tag;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Mostly well-formed reads carrying the expected tag; the rest is noise:
    // busy and error runs, refused starts, raised alerts and wrong tags.
    task automatic random_word();
        int         roll;
        logic [1:0] st;
        logic [7:0] hi;
        logic [7:0] lo;
        logic       refused;
        roll    = $urandom_range(0, 99);
        st      = BUS_IDLE;
        refused = ($urandom_range(0, 49) == 0);
        hi      = {1'($urandom_range(0, 1)), 1'b0, tag_hint, 4'($urandom_range(0, 15))};
        lo      = 8'($urandom_range(0, 255));
        if (run_left > 0)
        begin
            st = run_status;
            run_left--;
        end
        else if (roll < 8)
        begin
            st         = BUS_BUSY;
            run_status = BUS_BUSY;
            run_left   = $urandom_range(0, 7);
        end
        else if (roll < 12)
        begin
            st         = BUS_ERROR;
            run_status = BUS_ERROR;
            run_left   = $urandom_range(0, 7);
        end
        else if (roll < 14)
            st = BUS_UNKNOWN;
        else if (roll < 20)
            refused = 1'b1;
        else if (roll < 25)
            hi[ALERT_BIT] = 1'b1;
        else if (roll < 30)
            hi[TAG_LSB +: 2] = 2'($urandom_range(0, 3));
        put_word(st, hi, lo, refused);
    endtask

    // Drop valid, drain every expected word, then let the pipeline go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high across the pair.
    task automatic write_settings(input logic [7:0] limit_data, input logic [7:0] cmd);
        logic took;
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? CFG_TIMEOUT_LIMIT : CFG_COMMAND_BYTE;
            cfg_data  <= (r == 0) ? limit_data : cmd;
            do
            begin
                @(negedge clk);
                took = cfg_ready;
                @(posedge clk);
            end
            while (!took);
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: after each taken word, stall for a random number of cycles.
    initial
    begin : receiver
        int   stall_left;
        logic taking;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            taking = out_valid && !out_stall;
            @(posedge clk);
            if (taking)
                stall_left = quiet ? 0 : $urandom_range(0, 4);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when no channel moves for too long.
    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0] lim;
        logic [7:0] cmd;
        logic [7:0] spare;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk from reset, default limit 6 and command byte 0x70.
        put_word(BUS_IDLE, 8'h00, 8'h00, 1'b1);     // refused first transmit
        put_word(BUS_IDLE, 8'h00, 8'h00, 1'b0);     // transmit issued
        put_word(BUS_BUSY, 8'h00, 8'h00, 1'b0);     // wait on busy transmit
        put_word(BUS_IDLE, 8'h00, 8'h00, 1'b0);     // first receive issued
        put_word(BUS_IDLE, 8'h0F, 8'hFF, 1'b0);     // channel 0, full-scale code
        put_word(BUS_IDLE, 8'h10, 8'h00, 1'b0);     // channel 1, zero code
        put_word(BUS_IDLE, 8'hAA, 8'h5A, 1'b0);     // channel 2, top bit set
        put_word(BUS_IDLE, 8'h00, 8'h00, 1'b0);     // back to a receive
        put_word(BUS_IDLE, 8'h40, 8'h12, 1'b0);     // alert raised
        put_word(BUS_IDLE, 8'h20, 8'h34, 1'b0);     // wrong tag on channel 1
        put_word(BUS_IDLE, 8'hFF, 8'hFF, 1'b0);     // alert and tag 3
        put_word(BUS_IDLE, 8'h00, 8'h00, 1'b0);
        put_word(BUS_IDLE, 8'h05, 8'h33, 1'b1);     // good word, refused start
        put_word(BUS_ERROR, 8'h00, 8'h00, 1'b0);    // error before timeout
        put_word(BUS_UNKNOWN, 8'h00, 8'h00, 1'b0);  // status 3 acts as error
        repeat (4) put_word(BUS_BUSY, 8'h00, 8'h00, 1'b0);  // busy into timeout
        put_word(BUS_IDLE, 8'h15, 8'hC3, 1'b0);
        repeat (6) put_word(BUS_ERROR, 8'h00, 8'h00, 1'b0); // error into timeout

        // Random segments, each under its own register settings.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            spare = 8'($urandom_range(0, 255));
            case (seg)
                0: begin lim = 3'd1; cmd = 8'h00; end
                1: begin lim = 3'd7; cmd = 8'hFF; end
                2: begin lim = 3'd0; cmd = spare; end
                default:
                begin
                    lim = 3'($urandom_range(0, 7));
                    cmd = 8'($urandom_range(0, 255));
                end
            endcase
            // upper bits of the limit write are don't-care; exercise them
            write_settings({spare[7:3], lim}, cmd);
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                if (n % 40 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                random_word();
            end
        end

        settle();
        if (mismatches == 0 && pending_words == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
